FILE: design/ardc_pkg.sv
// shared types and constants for the audio ring drift corrector
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package ardc_pkg;

   localparam int RING_BYTES_DEF    = 4096;
   localparam int CHUNK_SAMPLES_DEF = 48;
   localparam int FRAME_BYTES_DEF   = 4;
   localparam int BYTES_PER_OUT     = 2;
   localparam int CFG_W             = 13;
   localparam int FILL_W            = 13;
   localparam int CSR_ADDR_W        = 3;
   localparam int CSR_DATA_W        = 32;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CHUNK = 1'b1;

   localparam logic REG_GOAL_FILL    = 1'b0;
   localparam logic REG_DRIFT_MARGIN = 1'b1;

   localparam logic [CFG_W-1:0] GOAL_FILL_RST    = 13'd2048;
   localparam logic [CFG_W-1:0] DRIFT_MARGIN_RST = 13'd256;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CORRECT,
      ST_DECIDE,
      ST_STREAM
   } ardc_state_type;

   typedef struct packed {
      logic clear;
      logic wr;
      logic correct;
      logic decide;
      logic issue;
      logic last;
   } ardc_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic out_free;
   } ardc_status_type;

endpackage

FILE: design/ardc_csr.sv
// configuration registers: target level and drift threshold behind an apb-style port
// depends on ardc_pkg
`timescale 1ns / 1ps

module ardc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ardc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ardc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ardc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output logic [ardc_pkg::CFG_W-1:0]         goal_fill,
   output logic [ardc_pkg::CFG_W-1:0]         drift_margin
);
   import ardc_pkg::*;

   logic [CFG_W-1:0] target_ff, target_in;
   logic [CFG_W-1:0] thresh_ff, thresh_in;
   logic             wr_en;
   logic [CFG_W-1:0] rd_val;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      target_in = target_ff;
      thresh_in = thresh_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            REG_GOAL_FILL:    target_in = csr_pwdata[CFG_W-1:0];
            REG_DRIFT_MARGIN: thresh_in = csr_pwdata[CFG_W-1:0];
            default:          target_in = target_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_GOAL_FILL:    rd_val = target_ff;
         REG_DRIFT_MARGIN: rd_val = thresh_ff;
         default:          rd_val = '0;
      endcase
   end

   assign csr_prdata = CSR_DATA_W'(rd_val);

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= GOAL_FILL_RST;
         thresh_ff <= DRIFT_MARGIN_RST;
      end else begin
         target_ff <= target_in;
         thresh_ff <= thresh_in;
      end
   end

   assign goal_fill    = target_ff;
   assign drift_margin = thresh_ff;

endmodule

FILE: design/ardc_ctrl.sv
// controller state machine: clearing pass, write items, chunk setup and sample streaming
// depends on ardc_pkg
`timescale 1ns / 1ps

module ardc_ctrl #(
   parameter int CHUNK_SAMPLES = ardc_pkg::CHUNK_SAMPLES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      opcode,
   output logic                      req_tready,
   input  ardc_pkg::ardc_status_type status,
   output ardc_pkg::ardc_cmd_type    cmd
);
   import ardc_pkg::*;

   localparam int SW = (CHUNK_SAMPLES > 1) ? $clog2(CHUNK_SAMPLES) : 1;

   ardc_state_type state_ff, state_in;
   logic [SW-1:0]  count_ff, count_in;
   logic           at_last;

   assign at_last = (count_ff == SW'(CHUNK_SAMPLES - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid && opcode == OP_CHUNK) state_in = ST_CORRECT;
         end
         ST_CORRECT: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = ST_STREAM;
            count_in = '0;
         end
         ST_STREAM: begin
            if (status.out_free) begin
               if (at_last) begin
                  state_in = ST_IDLE;
                  count_in = '0;
               end else begin
                  count_in = count_ff + SW'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR:   cmd.clear = 1'b1;
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.wr     = req_tvalid & (opcode == OP_WRITE);
         end
         ST_CORRECT: cmd.correct = 1'b1;
         ST_DECIDE:  cmd.decide = 1'b1;
         ST_STREAM: begin
            cmd.issue = status.out_free;
            cmd.last  = at_last;
         end
         default:    cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: design/ardc_datapath.sv
// datapath: two byte banks (even and odd addresses), pointers, fill count, drift correction
// and the result register; depends on ardc_pkg and commands from ardc_ctrl
`timescale 1ns / 1ps

module ardc_datapath #(
   parameter int RING_BYTES    = ardc_pkg::RING_BYTES_DEF,
   parameter int CHUNK_SAMPLES = ardc_pkg::CHUNK_SAMPLES_DEF,
   parameter int FRAME_BYTES   = ardc_pkg::FRAME_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ardc_pkg::ardc_cmd_type         cmd,
   output ardc_pkg::ardc_status_type      status,
   input  logic [7:0]                     data_byte,
   input  logic                           first_of_packet,
   input  logic [9:0]                     packet_len,
   input  logic [ardc_pkg::CFG_W-1:0]     goal_fill,
   input  logic [ardc_pkg::CFG_W-1:0]     drift_margin,
   input  logic                           rsp_tready,
   output logic                           rsp_valid,
   output logic signed [15:0]             sample,
   output logic                           last_of_chunk,
   output logic                           muted,
   output logic                           ready_to_play,
   output logic [ardc_pkg::FILL_W-1:0]    fill_level
);
   import ardc_pkg::*;

   localparam int PTR_W = $clog2(RING_BYTES);
   localparam int ROW_W = PTR_W - 1;
   localparam int ROWS  = RING_BYTES / 2;
   localparam int CNT_W = $clog2(RING_BYTES + 1);
   localparam int CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 2;
   localparam int NEED  = CHUNK_SAMPLES * BYTES_PER_OUT;

   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [CNT_W-1:0]  avail_ff, avail_in;
   logic              drop_ff, drop_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              mute_ff, mute_in;

   logic              valid_ff, valid_in;
   logic              last_ff, last_in;
   logic              muted_ff, muted_in;
   logic              ready_ff, ready_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              swap_ff, swap_in;

   logic [7:0]        bank0_mem [ROWS];
   logic [7:0]        bank1_mem [ROWS];
   logic [7:0]        rd0_ff, rd1_ff;

   logic [CMP_W-1:0]  avail_x, tgt_x, thr_x, hi_lvl, lo_lvl;
   logic [CMP_W-1:0]  skip_step, room, rep_step;
   logic              drop_now, wr_do;

   logic [PTR_W-1:0]  rp_plus1;
   logic [ROW_W-1:0]  rd_row0, rd_row1, wr_row;
   logic [7:0]        wr_data;
   logic              we0, we1, rd_en;
   logic [7:0]        lo_byte, hi_byte;

   assign avail_x = CMP_W'(avail_ff);
   assign tgt_x   = CMP_W'(goal_fill);
   assign thr_x   = CMP_W'(drift_margin);
   assign hi_lvl  = tgt_x + thr_x;
   assign lo_lvl  = (tgt_x > thr_x) ? (tgt_x - thr_x) : '0;

   assign skip_step = (avail_x < CMP_W'(FRAME_BYTES)) ? avail_x : CMP_W'(FRAME_BYTES);
   assign room      = CMP_W'(RING_BYTES) - avail_x;
   assign rep_step  = (room < CMP_W'(FRAME_BYTES)) ? room : CMP_W'(FRAME_BYTES);

   assign drop_now = first_of_packet ?
                     ((avail_x + CMP_W'(packet_len)) > CMP_W'(RING_BYTES)) : drop_ff;
   assign wr_do    = cmd.wr & ~drop_now & (avail_x < CMP_W'(RING_BYTES));

   always_comb begin
      wp_in    = wp_ff;
      rp_in    = rp_ff;
      avail_in = avail_ff;
      drop_in  = drop_ff;
      row_in   = row_ff;
      mute_in  = mute_ff;
      valid_in = valid_ff;
      last_in  = last_ff;
      muted_in = muted_ff;
      ready_in = ready_ff;
      fill_in  = fill_ff;
      swap_in  = swap_ff;

      if (cmd.clear) row_in = row_ff + ROW_W'(1);

      if (cmd.wr) begin
         if (first_of_packet) drop_in = drop_now;
         if (wr_do) begin
            wp_in    = wp_ff + PTR_W'(1);
            avail_in = avail_ff + CNT_W'(1);
         end
      end

      // frame skip or repeat
      if (cmd.correct) begin
         if (avail_x > hi_lvl) begin
            rp_in    = rp_ff + PTR_W'(skip_step);
            avail_in = CNT_W'(avail_x - skip_step);
         end else if (avail_x < lo_lvl) begin
            rp_in    = rp_ff - PTR_W'(rep_step);
            avail_in = CNT_W'(avail_x + rep_step);
         end
      end

      if (cmd.decide) begin
         mute_in = (avail_x < CMP_W'(NEED));
         if (!(avail_x < CMP_W'(NEED))) avail_in = CNT_W'(avail_x - CMP_W'(NEED));
      end

      if (cmd.issue) begin
         if (!mute_ff) rp_in = rp_ff + PTR_W'(BYTES_PER_OUT);
         valid_in = 1'b1;
         last_in  = cmd.last;
         muted_in = mute_ff;
         ready_in = (avail_x >= tgt_x);
         fill_in  = FILL_W'(avail_ff);
         swap_in  = rp_ff[0];
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   // bank addressing: byte p sits in bank p[0], row p>>1
   assign rp_plus1 = rp_ff + PTR_W'(1);
   assign rd_row0  = rp_ff[0] ? rp_plus1[PTR_W-1:1] : rp_ff[PTR_W-1:1];
   assign rd_row1  = rp_ff[PTR_W-1:1];
   assign rd_en    = cmd.issue & ~mute_ff;
   assign wr_row   = cmd.clear ? row_ff : wp_ff[PTR_W-1:1];
   assign wr_data  = cmd.clear ? 8'd0 : data_byte;
   assign we0      = cmd.clear | (wr_do & ~wp_ff[0]);
   assign we1      = cmd.clear | (wr_do & wp_ff[0]);

   always_ff @(posedge clock) begin
      if (we0) bank0_mem[wr_row] <= wr_data;
      if (rd_en) rd0_ff <= bank0_mem[rd_row0];
   end

   always_ff @(posedge clock) begin
      if (we1) bank1_mem[wr_row] <= wr_data;
      if (rd_en) rd1_ff <= bank1_mem[rd_row1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         avail_ff <= '0;
         drop_ff  <= 1'b0;
         row_ff   <= '0;
         mute_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         avail_ff <= avail_in;
         drop_ff  <= drop_in;
         row_ff   <= row_in;
         mute_ff  <= mute_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff  <= last_in;
      muted_ff <= muted_in;
      ready_ff <= ready_in;
      fill_ff  <= fill_in;
      swap_ff  <= swap_in;
   end

   assign lo_byte = swap_ff ? rd1_ff : rd0_ff;
   assign hi_byte = swap_ff ? rd0_ff : rd1_ff;

   assign status.clear_done = (row_ff == ROW_W'(ROWS - 1));
   assign status.out_free   = ~valid_ff | rsp_tready;

   assign rsp_valid     = valid_ff;
   assign sample        = muted_ff ? 16'sd0 : $signed({hi_byte, lo_byte});
   assign last_of_chunk = last_ff;
   assign muted         = muted_ff;
   assign ready_to_play = ready_ff;
   assign fill_level    = fill_ff;

endmodule

FILE: design/audio_ring_drift_corrector_top.sv
// top level of the audio ring drift corrector
// depends on ardc_pkg, ardc_csr, ardc_ctrl and ardc_datapath
`timescale 1ns / 1ps

// Byte ring between a packet source and a sample sink with frame skip/repeat.
// req channel: one item per byte write (tuser[0] = 0) or per chunk request
// (tuser[0] = 1); writes are accepted back to back. The first byte of a
// packet (tuser[1]) checks whether the whole packet fits; if not, every byte
// of that packet is dropped. A chunk request gives CHUNK_SAMPLES items on rsp:
// a frame correction step (state CORRECT), an underrun check (state DECIDE),
// then one sample per cycle while the output register is free, read from two
// byte banks in parallel and registered in the output register. The next
// item is accepted as soon as the last sample of a chunk has been issued,
// while that sample may still sit in the output register. If rsp_tready is
// low the output register holds and streaming pauses. Target level and drift
// threshold are set through the csr port. After reset the ring is cleared to
// zero, one row of both banks per cycle, with req_tready low until the last
// row is written; csr writes are taken throughout. RING_BYTES must be a power
// of two; the block does not check it.
module audio_ring_drift_corrector_top #(
   parameter int RING_BYTES    = ardc_pkg::RING_BYTES_DEF,
   parameter int CHUNK_SAMPLES = ardc_pkg::CHUNK_SAMPLES_DEF,
   parameter int FRAME_BYTES   = ardc_pkg::FRAME_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [23:0]                      req_tdata,  // data_byte[7:0], packet_len[17:8]
   input  logic [1:0]                       req_tuser,  // opcode[0], first_of_packet[1]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [31:0]                      rsp_tdata,  // sample[15:0], fill_level[28:16]
   output logic [1:0]                       rsp_tuser,  // muted[0], ready_to_play[1]
   output logic                             rsp_tlast,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ardc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ardc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ardc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import ardc_pkg::*;

   ardc_cmd_type      cmd;
   ardc_status_type   status;
   logic [CFG_W-1:0]  goal_fill;
   logic [CFG_W-1:0]  drift_margin;
   logic signed [15:0] sample;
   logic              muted;
   logic              ready_to_play;
   logic [FILL_W-1:0] fill_level;

   ardc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .goal_fill    (goal_fill),
      .drift_margin (drift_margin)
   );

   ardc_ctrl #(
      .CHUNK_SAMPLES (CHUNK_SAMPLES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .opcode     (req_tuser[0]),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ardc_datapath #(
      .RING_BYTES    (RING_BYTES),
      .CHUNK_SAMPLES (CHUNK_SAMPLES),
      .FRAME_BYTES   (FRAME_BYTES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .data_byte       (req_tdata[7:0]),
      .first_of_packet (req_tuser[1]),
      .packet_len      (req_tdata[17:8]),
      .goal_fill       (goal_fill),
      .drift_margin    (drift_margin),
      .rsp_tready      (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .sample          (sample),
      .last_of_chunk   (rsp_tlast),
      .muted           (muted),
      .ready_to_play   (ready_to_play),
      .fill_level      (fill_level)
   );

   assign rsp_tdata = {3'b000, fill_level, sample};
   assign rsp_tuser = {ready_to_play, muted};

endmodule

FILE: tb/sv/tb_audio_ring_drift_corrector_top.sv
// self-checking testbench for audio_ring_drift_corrector_top: byte writes, chunk reads,
// frame skip/repeat and underrun muting checked against an in-bench ring predictor
// depends on ardc_pkg and the audio_ring_drift_corrector_top rtl
`timescale 1ns / 1ps

module tb_audio_ring_drift_corrector_top;
   import ardc_pkg::*;

   localparam int RING_SIZE   = RING_BYTES_DEF;
   localparam int CHUNK_LEN   = CHUNK_SAMPLES_DEF;
   localparam int FRAME_SIZE  = FRAME_BYTES_DEF;
   localparam int CHUNK_BYTES = CHUNK_LEN * BYTES_PER_OUT;
   localparam int DRAIN_WAIT  = 8;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic       op;
      logic [7:0] data;
      logic       first;
      logic [9:0] plen;
   } ring_item_type;

   typedef struct packed {
      logic [15:0]       sample;
      logic              last;
      logic              muted;
      logic              ready;
      logic [FILL_W-1:0] fill;
   } play_sample_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // ring predictor state
   logic [7:0]  ring_mirror [0:RING_SIZE-1];
   logic [11:0] wr_ptr_m = '0;
   logic [11:0] rd_ptr_m = '0;
   int          held_bytes = 0;
   bit          dropping_m = 1'b0;
   int          target_m = GOAL_FILL_RST;
   int          thresh_m = DRIFT_MARGIN_RST;

   ring_item_type   pending_items [$];
   play_sample_type expected_samples [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;

   int error_count = 0;
   int items_accepted = 0;
   int bytes_stored = 0;
   int bytes_dropped = 0;
   int chunks_requested = 0;
   int muted_chunks = 0;
   int skips_done = 0;
   int repeats_done = 0;
   int samples_checked = 0;

   audio_ring_drift_corrector_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < RING_SIZE; i++) ring_mirror[i] = 8'h00;
   end

   // one accepted item through the ring predictor
   function automatic void apply_item(logic op, logic [7:0] data, logic first,
                                      logic [9:0] plen);
      int              hi_lim;
      int              lo_lim;
      int              step;
      bit              mute;
      logic [7:0]      lo8;
      logic [7:0]      hi8;
      play_sample_type s;
      if (op == OP_WRITE) begin
         if (first) dropping_m = (held_bytes + int'(plen)) > RING_SIZE;
         if (!dropping_m && held_bytes < RING_SIZE) begin
            ring_mirror[wr_ptr_m] = data;
            wr_ptr_m = wr_ptr_m + 12'd1;
            held_bytes++;
            bytes_stored++;
         end else begin
            bytes_dropped++;
         end
         return;
      end
      chunks_requested++;
      hi_lim = target_m + thresh_m;
      lo_lim = (target_m > thresh_m) ? target_m - thresh_m : 0;
      if (held_bytes > hi_lim) begin
         step = (FRAME_SIZE > held_bytes) ? held_bytes : FRAME_SIZE;
         rd_ptr_m = rd_ptr_m + 12'(step);
         held_bytes -= step;
         skips_done++;
      end else if (held_bytes < lo_lim) begin
         step = (FRAME_SIZE > RING_SIZE - held_bytes) ? RING_SIZE - held_bytes : FRAME_SIZE;
         rd_ptr_m = rd_ptr_m - 12'(step);
         held_bytes += step;
         repeats_done++;
      end
      mute = held_bytes < CHUNK_BYTES;
      if (mute) muted_chunks++;
      else held_bytes -= CHUNK_BYTES;
      for (int i = 0; i < CHUNK_LEN; i++) begin
         s.sample = 16'h0000;
         if (!mute) begin
            lo8 = ring_mirror[rd_ptr_m];
            rd_ptr_m = rd_ptr_m + 12'd1;
            hi8 = ring_mirror[rd_ptr_m];
            rd_ptr_m = rd_ptr_m + 12'd1;
            s.sample = {hi8, lo8};
         end
         s.last  = (i == CHUNK_LEN - 1);
         s.muted = mute;
         s.ready = held_bytes >= target_m;
         s.fill  = FILL_W'(held_bytes);
         expected_samples.push_back(s);
      end
   endfunction

   function automatic void check_field(string name, logic signed [31:0] exp_v,
                                       logic signed [31:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         error_count++;
      end
   endfunction

   // driver
   always @(posedge clock) begin
      ring_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_items.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {6'b0, nxt.plen, nxt.data};
            req_tuser  <= {nxt.first, nxt.op};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver stall, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         hold_left <= HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end
   end

   always @(posedge clock) begin
      if (reset || hold_left != 0) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(99) >= recv_idle_pct;
      end
   end

   // monitor
   always @(posedge clock) begin
      play_sample_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            items_accepted++;
            apply_item(req_tuser[0], req_tdata[7:0], req_tuser[1], req_tdata[17:8]);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               $error("unexpected result item: tdata %h tuser %b tlast %b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               error_count++;
            end else begin
               want = expected_samples.pop_front();
               samples_checked++;
               check_field("sample", $signed(want.sample), $signed(rsp_tdata[15:0]));
               check_field("fill_level", want.fill, rsp_tdata[28:16]);
               check_field("muted", want.muted, rsp_tuser[0]);
               check_field("ready_to_play", want.ready, rsp_tuser[1]);
               check_field("last_of_chunk", want.last, rsp_tlast);
            end
         end
      end
   end

   task automatic queue_write(logic [7:0] data, logic first, logic [9:0] plen);
      ring_item_type it;
      it = '{op: OP_WRITE, data: data, first: first, plen: plen};
      pending_items.push_back(it);
   endtask

   task automatic queue_chunk();
      ring_item_type it;
      it = '{op: OP_CHUNK, data: 8'($urandom), first: 1'($urandom), plen: 10'($urandom)};
      pending_items.push_back(it);
   endtask

   task automatic queue_packet(int len, int plen);
      queue_write(8'($urandom), 1'b1, 10'(plen));
      for (int i = 1; i < len; i++) queue_write(8'($urandom), 1'b0, 10'($urandom));
   endtask

   // mostly short well-formed packets and chunk requests, some stray bytes
   task automatic queue_traffic(int count);
      int pick;
      int len;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(10, 16) : $urandom_range(1, 6);
            queue_packet(len, ($urandom_range(9) == 0) ? $urandom_range(0, 1023) : len);
         end else if (pick < 92) begin
            queue_chunk();
         end else if (pick < 96) begin
            queue_write(8'($urandom), 1'b0, 10'($urandom));
         end else begin
            queue_packet($urandom_range(1, 4), 1023);
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_samples.size() != 0);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic csr_access(logic write, logic idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      if (!write && csr_prdata[CFG_W-1:0] !== value[CFG_W-1:0]) begin
         $error("register %0d readback mismatch: expected %0d, got %0d",
                idx, value[CFG_W-1:0], csr_prdata[CFG_W-1:0]);
         error_count++;
      end
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_levels(int target, int thresh);
      csr_access(1'b1, REG_GOAL_FILL, target);
      csr_access(1'b1, REG_DRIFT_MARGIN, thresh);
      target_m = target;
      thresh_m = thresh;
      csr_access(1'b0, REG_GOAL_FILL, target);
      csr_access(1'b0, REG_DRIFT_MARGIN, thresh);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // zero target and threshold: every chunk with data skips a frame
      send_idle_pct = 10;
      recv_idle_pct = 63;
      set_levels(0, 0);
      queue_chunk();
      queue_write(8'h00, 1'b0, 10'h3FF);
      queue_write(8'hFF, 1'b0, 10'h000);
      queue_write(8'hA5, 1'b0, 10'h155);
      queue_chunk();
      queue_write(8'h80, 1'b1, 10'd1023);
      queue_write(8'h7F, 1'b0, 10'h2AA);
      queue_write(8'h01, 1'b0, 10'h000);
      queue_chunk();
      queue_write(8'hFE, 1'b1, 10'd0);
      queue_chunk();
      queue_traffic(6);
      wait_drained();

      // full target, no margin: every chunk repeats a frame, muted until one can play,
      // the read pointer stepping back across the wrap
      set_levels(RING_SIZE, 0);
      queue_packet(24, 24);
      repeat (20) queue_chunk();
      queue_packet(3, 1023);
      queue_chunk();
      wait_drained();

      // widest window: no correction
      send_idle_pct = 63;
      recv_idle_pct = 10;
      set_levels(RING_SIZE, RING_SIZE);
      queue_traffic(10);
      wait_drained();

      // reset levels, receiver held off while the sender keeps offering
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_levels(GOAL_FILL_RST, DRIFT_MARGIN_RST);
      queue_traffic(8);
      queue_chunk();
      queue_packet(12, 12);
      repeat (3) queue_chunk();
      hold_requests = hold_requests + 1;
      wait_drained();

      for (int p = 0; p < 2; p++) begin
         set_levels($urandom_range(0, RING_SIZE), $urandom_range(0, 600));
         queue_traffic(3);
         wait_drained();
      end

      repeat (60) @(negedge clock);
      $display("covered %0d items: %0d bytes stored, %0d dropped, %0d chunks (%0d muted)",
               items_accepted, bytes_stored, bytes_dropped, chunks_requested, muted_chunks);
      $display("frame skips %0d, frame repeats %0d, samples checked %0d",
               skips_done, repeats_done, samples_checked);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $error("timeout with %0d items pending and %0d results outstanding",
             pending_items.size(), expected_samples.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: filelist.f
design/ardc_pkg.sv
design/ardc_csr.sv
design/ardc_ctrl.sv
design/ardc_datapath.sv
design/audio_ring_drift_corrector_top.sv
tb/sv/tb_audio_ring_drift_corrector_top.sv
